FILE: rtl/round_robin_time_slice_scheduler_core_defines.svh
// Assertion macros used by rrts_dp of the round-robin scheduler.
// Depends on nothing; assumes a clock i_clk and reset i_rst_n in the using module.
`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_CORE_DEFINES_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RRTS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define RRTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RRTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RRTS_ASSERT(lbl, cond, msg)
`define RRTS_ASSERT_IMP(lbl, ante, cons, msg)
`define RRTS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/rrts_pkg.sv
// Shared types and constants of the round-robin scheduler.
// Used by rrts_ctrl, rrts_dp and the top level; depends on nothing.
package rrts_pkg;

    localparam int BURST_W = 16;
    localparam int QUANT_W = 16;
    localparam int PCNT_W  = 5;
    localparam int CFG_W   = 16;
    localparam int CFGA_W  = 1;

    localparam logic [CFGA_W-1:0] REG_QUANTUM = 1'd0;
    localparam logic [CFGA_W-1:0] REG_PCOUNT  = 1'd1;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SCAN   = 8'b0000_0010,
        ST_DISP   = 8'b0000_0100,
        ST_POP1   = 8'b0000_1000,
        ST_POP2   = 8'b0001_0000,
        ST_RUN    = 8'b0010_0000,
        ST_FINISH = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic accept;     // item taken: latch tick time, clear result
        logic load_we;    // write process entry
        logic scan_init;  // first arrival scan of the run
        logic scan_step;
        logic pop_issue;
        logic pop_addr;
        logic pop_check;
        logic run;
        logic finish;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic cur_valid;
        logic fifo_empty;
        logic pop_zero;
        logic run_started;
        logic at_max;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/rrts_ctrl.sv
// Round-robin sequencer: writes loads, steps ticks through scan, dispatch and run.
// Depends on rrts_pkg.
module rrts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_func,
    output logic           o_stall,
    input  rrts_pkg::t_sts i_sts,
    output rrts_pkg::t_cmd o_cmd
);

    rrts_pkg::t_state r_state, n_state;
    logic             r_phase, n_phase;   // 0: scan before first dispatch, 1: scan after run

    assign o_stall = (r_state != rrts_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd   = '0;
        case (r_state)
            rrts_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_func == rrts_pkg::FUNC_LOAD) begin
                        o_cmd.load_we = 1'b1;
                        n_state = rrts_pkg::ST_DONE;
                    end else if (!i_sts.run_started) begin
                        o_cmd.scan_init = 1'b1;
                        n_phase = 1'b0;
                        n_state = rrts_pkg::ST_SCAN;
                    end else begin
                        n_state = rrts_pkg::ST_DISP;
                    end
                end
            end
            rrts_pkg::ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = r_phase ? rrts_pkg::ST_FINISH : rrts_pkg::ST_DISP;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            rrts_pkg::ST_DISP: begin
                if (i_sts.cur_valid || i_sts.fifo_empty) begin
                    n_state = rrts_pkg::ST_RUN;
                end else begin
                    o_cmd.pop_issue = 1'b1;
                    n_state = rrts_pkg::ST_POP1;
                end
            end
            rrts_pkg::ST_POP1: begin
                o_cmd.pop_addr = 1'b1;
                n_state = rrts_pkg::ST_POP2;
            end
            rrts_pkg::ST_POP2: begin
                o_cmd.pop_check = 1'b1;
                n_state = i_sts.pop_zero ? rrts_pkg::ST_DISP : rrts_pkg::ST_RUN;
            end
            rrts_pkg::ST_RUN: begin
                o_cmd.run = 1'b1;
                if (i_sts.at_max) begin
                    n_state = rrts_pkg::ST_FINISH;
                end else begin
                    n_phase = 1'b1;
                    n_state = rrts_pkg::ST_SCAN;
                end
            end
            rrts_pkg::ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = rrts_pkg::ST_DONE;
            end
            rrts_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = rrts_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rrts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrts_pkg::ST_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

endmodule

FILE: rtl/rrts_dp.sv
// Datapath of the round-robin scheduler: process tables, ready queue, timing and result register.
// Depends on rrts_pkg and the assertion macro header.
`include "round_robin_time_slice_scheduler_core_defines.svh"
module rrts_dp #(
    parameter int MAX_PROCS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rrts_pkg::t_cmd               i_cmd,
    output rrts_pkg::t_sts               o_sts,
    input  logic [3:0]                   i_proc_index,
    input  logic [TIME_BITS-1:0]         i_arrival_time,
    input  logic [rrts_pkg::BURST_W-1:0] i_burst_time,
    input  logic                         i_cfg_we,
    input  logic [rrts_pkg::CFGA_W-1:0]  i_cfg_addr,
    input  logic [rrts_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic                         o_running_valid,
    output logic [3:0]                   o_running_index,
    output logic                         o_slice_start,
    output logic [TIME_BITS-1:0]         o_tick_time,
    output logic                         o_all_done
);

    localparam int IW = $clog2(MAX_PROCS);
    localparam int CW = IW + 1;
    localparam int AW = (IW >= 4) ? IW + 1 : 5;
    localparam logic [IW-1:0] LAST = IW'(MAX_PROCS - 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_PROCS);

    logic [rrts_pkg::QUANT_W-1:0] r_quantum;
    logic [rrts_pkg::PCNT_W-1:0]  r_pcount;

    logic [TIME_BITS-1:0]         r_arr_mem [MAX_PROCS];
    logic [rrts_pkg::BURST_W-1:0] r_rem_mem [MAX_PROCS];
    logic [IW-1:0]                r_fifo_mem [MAX_PROCS];
    logic [TIME_BITS-1:0]         r_arr_rd;
    logic [rrts_pkg::BURST_W-1:0] r_rem_rd;
    logic [IW-1:0]                r_fifo_rd;
    logic [IW-1:0]                r_pop_idx;

    logic [IW-1:0] r_head, r_tail;
    logic [CW-1:0] r_fill;
    logic [TIME_BITS-1:0] r_now;
    logic [IW-1:0] r_cur;
    logic          r_cur_valid;
    logic [rrts_pkg::BURST_W-1:0] r_cur_rem;
    logic [rrts_pkg::QUANT_W-1:0] r_slice;
    logic [CW-1:0] r_finished;
    logic          r_started;
    logic [CW-1:0] r_scan_idx;
    logic          r_scan_pend;
    logic [IW-1:0] r_scan_pidx;

    logic          r_res_rv, r_res_ss;
    logic [IW-1:0] r_res_ri;
    logic [TIME_BITS-1:0] r_res_tt;
    logic          r_out_valid;

    logic [AW-1:0] load_idx;
    logic          load_ok;
    logic [7:0]    pc_wide;
    logic [CW-1:0] active;
    logic          at_max;
    logic          scan_issue;
    logic          scan_hit;
    logic          preempt;
    logic          cur_retire;
    logic          pop_retire;
    logic          push_req, push_ok;
    logic [IW-1:0] push_data;
    logic          rem_wb;
    logic          rem_we;
    logic [IW-1:0] rem_waddr;
    logic [rrts_pkg::BURST_W-1:0] rem_wdata;
    logic          retire;

    assign load_idx = AW'(i_proc_index);
    assign load_ok  = i_cmd.load_we && (load_idx < AW'(MAX_PROCS));
    assign pc_wide  = 8'(r_pcount);
    assign active   = (pc_wide > 8'(MAX_PROCS)) ? MAXC : CW'(r_pcount);
    assign at_max   = (r_now == '1);

    assign scan_issue = i_cmd.scan_step && (r_scan_idx < active);
    assign scan_hit   = i_cmd.scan_step && r_scan_pend && (r_arr_rd == r_now);
    assign cur_retire = i_cmd.finish && r_cur_valid && (r_cur_rem == '0);
    assign preempt    = i_cmd.finish && r_cur_valid && (r_cur_rem != '0) &&
                        (r_slice >= r_quantum);
    assign pop_retire = i_cmd.pop_check && (r_rem_rd == '0);
    assign retire     = cur_retire || pop_retire;

    assign push_req  = scan_hit || preempt;
    assign push_data = preempt ? r_cur : r_scan_pidx;
    assign push_ok   = push_req && (r_fill < MAXC);

    // Write the running entry's remaining time back at the end of every tick that has one
    assign rem_wb    = i_cmd.finish && r_cur_valid;
    assign rem_we    = load_ok || rem_wb;
    assign rem_waddr = rem_wb ? r_cur : load_idx[IW-1:0];
    assign rem_wdata = rem_wb ? r_cur_rem : i_burst_time;

    // Tables and ready queue
    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            r_arr_mem[load_idx[IW-1:0]] <= i_arrival_time;
        end
        if (scan_issue) begin
            r_arr_rd <= r_arr_mem[r_scan_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rem_we) begin
            r_rem_mem[rem_waddr] <= rem_wdata;
        end
        if (i_cmd.pop_addr) begin
            r_rem_rd <= r_rem_mem[r_fifo_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_fifo_mem[r_tail] <= push_data;
        end
        if (i_cmd.pop_issue) begin
            r_fifo_rd <= r_fifo_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop_addr) begin
            r_pop_idx <= r_fifo_rd;
        end
        if (i_cmd.scan_step) begin
            r_scan_pidx <= r_scan_idx[IW-1:0];
        end
        if (i_cmd.accept) begin
            r_res_tt <= r_now;
        end
        if (i_cmd.out_load) begin
            o_running_valid <= r_res_rv;
            o_running_index <= 4'(r_res_ri);
            o_slice_start   <= r_res_ss;
            o_tick_time     <= r_res_tt;
            o_all_done      <= (r_finished >= active);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum   <= rrts_pkg::QUANT_W'(1);
            r_pcount    <= rrts_pkg::PCNT_W'(1);
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_now       <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_cur_rem   <= '0;
            r_slice     <= '0;
            r_finished  <= '0;
            r_started   <= 1'b0;
            r_scan_idx  <= '0;
            r_scan_pend <= 1'b0;
            r_res_rv    <= 1'b0;
            r_res_ss    <= 1'b0;
            r_res_ri    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    rrts_pkg::REG_QUANTUM: r_quantum <= i_cfg_data;
                    rrts_pkg::REG_PCOUNT:  r_pcount  <= i_cfg_data[rrts_pkg::PCNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                r_res_rv <= 1'b0;
                r_res_ss <= 1'b0;
                r_res_ri <= '0;
            end
            // Restart the scan counter for a new arrival sweep
            if (i_cmd.scan_init || (i_cmd.run && !at_max)) begin
                r_scan_idx  <= '0;
                r_scan_pend <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_scan_pend <= scan_issue;
                if (scan_issue) begin
                    r_scan_idx <= r_scan_idx + CW'(1);
                end
            end
            if (i_cmd.scan_init) begin
                r_started <= 1'b1;
            end
            if (push_ok) begin
                r_tail <= (r_tail == LAST) ? '0 : r_tail + IW'(1);
            end
            if (i_cmd.pop_issue) begin
                r_head <= (r_head == LAST) ? '0 : r_head + IW'(1);
            end
            r_fill <= r_fill + CW'(push_ok) - CW'(i_cmd.pop_issue);
            if (retire && (r_finished < MAXC)) begin
                r_finished <= r_finished + CW'(1);
            end
            // A load of the running entry replaces its remaining time
            if (load_ok && r_cur_valid && (load_idx[IW-1:0] == r_cur)) begin
                r_cur_rem <= i_burst_time;
            end
            // Dispatch a dequeued entry with time left
            if (i_cmd.pop_check && !pop_retire) begin
                r_cur       <= r_pop_idx;
                r_cur_rem   <= r_rem_rd;
                r_cur_valid <= 1'b1;
                r_slice     <= '0;
                r_res_ss    <= 1'b1;
            end
            if (i_cmd.run) begin
                if (r_cur_valid) begin
                    r_res_rv  <= 1'b1;
                    r_res_ri  <= r_cur;
                    r_cur_rem <= r_cur_rem - rrts_pkg::BURST_W'(1);
                    r_slice   <= r_slice + rrts_pkg::QUANT_W'(1);
                end
                if (!at_max) begin
                    r_now <= r_now + TIME_BITS'(1);
                end
            end
            if (cur_retire || preempt) begin
                r_cur_valid <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;

    always_comb begin
        o_sts             = '0;
        o_sts.scan_done   = (r_scan_idx >= active) && !r_scan_pend;
        o_sts.cur_valid   = r_cur_valid;
        o_sts.fifo_empty  = (r_fill == '0);
        o_sts.pop_zero    = (r_rem_rd == '0);
        o_sts.run_started = r_started;
        o_sts.at_max      = at_max;
        o_sts.out_free    = !r_out_valid || !i_stall;
    end

    `RRTS_ASSERT(a_fill_bound, r_fill <= MAXC, "ready queue fill above depth")
    `RRTS_ASSERT_IMP(a_pop_nonempty, i_cmd.pop_issue, r_fill != '0, "pop from empty queue")
    `RRTS_ASSERT_NXT(a_retire_clears, cur_retire, !r_cur_valid && (r_finished != '0),
        "retired process still running")
    `RRTS_ASSERT(a_finish_bound, r_finished <= MAXC, "finish count above process limit")

endmodule

FILE: rtl/round_robin_time_slice_scheduler_core.sv
// Top level of the round-robin time-slice scheduler.
// Depends on rrts_pkg, rrts_ctrl and rrts_dp.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one transaction per item: a load
//   (i_func = 0) writes arrival and burst time of entry i_proc_index, a tick
//   (i_func = 1) advances time by one unit, saturating at its maximum. Every
//   transaction returns exactly one result transaction on the output channel
//   (o_valid / i_stall): the process that ran in that tick, a slice start
//   flag, the tick start time and the all-done flag.
//   Sequence: a load writes its entry on acceptance, then returns its result.
//   A tick runs the time step, then an arrival sweep over the active entries
//   unless time is at its maximum, then ends the slice; the first tick of a
//   run also sweeps before dispatch. Each dequeue passes ST_POP1 and ST_POP2,
//   and zero-burst entries are retired on the way. The sweep reads one table
//   entry per cycle through a single read port.
//   Only one item is in work at a time; o_stall is high while it is. The result
//   sits in an output register, so a new transaction is taken while the
//   receiver stalls; a finished item then waits until the register frees up.
//   Reset (synchronous, i_rst_n low) clears queue, time, counters and result
//   valid; quantum and process count return to 1; the tables stay undefined.
module round_robin_time_slice_scheduler_core #(
    parameter int MAX_PROCS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_func,
    input  logic [3:0]                   i_proc_index,
    input  logic [TIME_BITS-1:0]         i_arrival_time,
    input  logic [rrts_pkg::BURST_W-1:0] i_burst_time,
    input  logic                         i_cfg_we,
    input  logic [rrts_pkg::CFGA_W-1:0]  i_cfg_addr,
    input  logic [rrts_pkg::CFG_W-1:0]   i_cfg_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_running_valid,
    output logic [3:0]                   o_running_index,
    output logic                         o_slice_start,
    output logic [TIME_BITS-1:0]         o_tick_time,
    output logic                         o_all_done
);

    rrts_pkg::t_cmd cmd;
    rrts_pkg::t_sts sts;

    // Sequence each tick: sweep arrivals, dequeue, run, requeue
    rrts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Hold the tables, ready queue, clock and result register
    rrts_dp #(
        .MAX_PROCS (MAX_PROCS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_proc_index    (i_proc_index),
        .i_arrival_time  (i_arrival_time),
        .i_burst_time    (i_burst_time),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_running_valid (o_running_valid),
        .o_running_index (o_running_index),
        .o_slice_start   (o_slice_start),
        .o_tick_time     (o_tick_time),
        .o_all_done      (o_all_done)
    );

endmodule
